[design/tga_rle_pixel_decoder_core_defines.svh]
// Assertion helpers used by the checker file.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TGA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tga_rle_pkg.sv]
`default_nettype none
package tga_rle_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int PIX_BITS       = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] RUN_BIAS  = 8'd127;
    localparam logic [2:0] BPP_RESET = 3'd4;
    localparam logic [2:0] BPP_MIN   = 3'd1;
    localparam logic [2:0] BPP_MAX   = 3'd4;

    typedef enum logic [0:0] {
        CFG_BPP   = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_reg;

    // One completed raw pixel or run handed from the parser to the pixel counter.
    typedef struct packed {
        logic                run;
        logic [7:0]          count;
        logic                more;
        logic [PIX_BITS-1:0] value;
    } t_item;

endpackage
`default_nettype wire

[design/tga_rle_in_if.sv]
`default_nettype none
interface tga_rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

[design/tga_rle_out_if.sv]
`default_nettype none
interface tga_rle_out_if #(
    parameter int COUNT_BITS = tga_rle_pkg::COUNT_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [tga_rle_pkg::PIX_BITS-1:0]  pixel_value;
    logic [7:0]                        repeat_count;
    logic [COUNT_BITS-1:0]             first_index;
    logic                              overrun;
    logic                              image_complete;

    modport source (output valid, output pixel_value, output repeat_count,
                    output first_index, output overrun, output image_complete,
                    input ready);
    modport sink (input valid, input pixel_value, input repeat_count,
                  input first_index, input overrun, input image_complete,
                  output ready);
endinterface
`default_nettype wire

[design/tga_rle_cfg_if.sv]
`default_nettype none
interface tga_rle_cfg_if #(
    parameter int COUNT_BITS = tga_rle_pkg::COUNT_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    tga_rle_pkg::t_cfg_reg   index;
    logic [COUNT_BITS:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/tga_rle_fifo.sv]
`default_nettype none
module tga_rle_fifo #(
    parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  tga_rle_pkg::t_item  i_push_item,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready,
    output tga_rle_pkg::t_item  o_pop_item
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    tga_rle_pkg::t_item  r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_fill, n_fill;
    logic                w_push;
    logic                w_pop;

    assign o_push_ready = (r_fill != CNT_BITS'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_fill = r_fill + CNT_BITS'(w_push) - CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end
endmodule
`default_nettype wire

[design/tga_rle_front.sv]
`default_nettype none
module tga_rle_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [2:0]          i_bpp,
    input  wire                 i_stop,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_data_byte,
    output logic                o_push_valid,
    input  wire                 i_push_ready,
    output tga_rle_pkg::t_item  o_item
);
    logic                             r_expect, n_expect;
    logic                             r_run, n_run;
    logic [7:0]                       r_left, n_left;
    logic [1:0]                       r_bip, n_bip;
    logic [tga_rle_pkg::PIX_BITS-1:0] r_asm, n_asm;
    logic                             r_halt;
    logic [2:0]                       w_width;
    logic                             w_last;
    logic [7:0]                       w_left_dec;
    logic                             w_take;
    logic                             w_drop;

    // Clamp the configured byte width into 1..4.
    always_comb begin
        if (i_bpp < tga_rle_pkg::BPP_MIN) begin
            w_width = tga_rle_pkg::BPP_MIN;
        end else if (i_bpp > tga_rle_pkg::BPP_MAX) begin
            w_width = tga_rle_pkg::BPP_MAX;
        end else begin
            w_width = i_bpp;
        end
    end

    assign w_last     = ({1'b0, r_bip} + 3'd1) >= w_width;
    assign w_left_dec = r_left - 8'd1;
    assign o_ready    = i_push_ready;
    assign w_take     = i_valid && o_ready;
    // Drop every byte once the pixel counter has reached the image size.
    assign w_drop     = r_halt || i_stop;

    always_comb begin
        n_expect     = r_expect;
        n_run        = r_run;
        n_left       = r_left;
        n_bip        = r_bip;
        n_asm        = r_asm;
        o_push_valid = 1'b0;
        o_item.run   = r_run;
        o_item.count = r_left;
        o_item.more  = 1'b0;
        o_item.value = (r_bip == 2'd0) ? {24'd0, i_data_byte} : {r_asm[23:0], i_data_byte};
        if (r_expect) begin
            n_run    = i_data_byte[7];
            n_left   = i_data_byte[7] ? (i_data_byte - tga_rle_pkg::RUN_BIAS)
                                      : (i_data_byte + 8'd1);
            n_expect = 1'b0;
            n_bip    = 2'd0;
            n_asm    = '0;
        end else if (!w_last) begin
            n_bip = r_bip + 2'd1;
            n_asm = o_item.value;
        end else begin
            n_bip        = 2'd0;
            n_asm        = o_item.value;
            o_push_valid = i_valid && !w_drop;
            if (r_run) begin
                n_left   = 8'd0;
                n_expect = 1'b1;
            end else begin
                o_item.count = 8'd1;
                o_item.more  = (w_left_dec != 8'd0);
                n_left       = w_left_dec;
                n_expect     = (w_left_dec == 8'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= 1'b1;
            r_run    <= 1'b0;
            r_left   <= '0;
            r_bip    <= '0;
            r_halt   <= 1'b0;
        end else if (w_take) begin
            if (w_drop) begin
                r_halt <= 1'b1;
            end else begin
                r_expect <= n_expect;
                r_run    <= n_run;
                r_left   <= n_left;
                r_bip    <= n_bip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !w_drop) begin
            r_asm <= n_asm;
        end
    end
endmodule
`default_nettype wire

[design/tga_rle_back.sv]
`default_nettype none
module tga_rle_back #(
    parameter int COUNT_BITS = tga_rle_pkg::COUNT_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [COUNT_BITS:0]                i_pixel_count,
    output logic                               o_stop,
    input  wire                                i_pop_valid,
    output logic                               o_pop_ready,
    input  tga_rle_pkg::t_item                 i_item,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [tga_rle_pkg::PIX_BITS-1:0]   o_pixel_value,
    output logic [7:0]                         o_repeat_count,
    output logic [COUNT_BITS-1:0]              o_first_index,
    output logic                               o_overrun,
    output logic                               o_image_complete
);
    localparam int CW = COUNT_BITS + 1;

    logic                             r_valid;
    logic                             r_halted;
    logic [CW-1:0]                    r_written;
    logic [tga_rle_pkg::PIX_BITS-1:0] r_value;
    logic [7:0]                       r_repeat;
    logic [COUNT_BITS-1:0]            r_first;
    logic                             r_over;
    logic                             r_done;

    logic                             w_take;
    logic                             w_blocked;
    logic [7:0]                       w_rep_in;
    logic [CW:0]                      w_sum;
    logic                             w_past;
    logic [CW-1:0]                    w_gap;
    logic [7:0]                       w_rep_out;
    logic [CW-1:0]                    w_written_new;
    logic                             w_done;
    logic                             w_over;

    assign o_pop_ready = !r_valid || i_ready;
    assign w_take      = i_pop_valid && o_pop_ready;
    assign w_blocked   = r_halted || (r_written >= i_pixel_count);
    assign o_stop      = w_blocked;

    always_comb begin
        if (!i_item.run) begin
            w_rep_in = 8'd1;
        end else if (i_item.count == 8'd0) begin
            w_rep_in = 8'd1;
        end else begin
            w_rep_in = i_item.count;
        end
        w_sum         = {1'b0, r_written} + {{(CW + 1 - 8){1'b0}}, w_rep_in};
        w_past        = w_sum > {1'b0, i_pixel_count};
        w_gap         = i_pixel_count - r_written;
        // Cut a run to the pixels still missing.
        w_rep_out     = w_past ? w_gap[7:0] : w_rep_in;
        w_written_new = w_past ? i_pixel_count : w_sum[CW-1:0];
        w_done        = w_sum >= {1'b0, i_pixel_count};
        w_over        = i_item.run ? w_past : (w_done && i_item.more);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_halted  <= 1'b0;
            r_written <= '0;
        end else begin
            if (w_take && !w_blocked) begin
                r_valid   <= 1'b1;
                r_written <= w_written_new;
                r_halted  <= w_done;
            end else begin
                if (i_ready) begin
                    r_valid <= 1'b0;
                end
                if (w_take) begin
                    r_halted <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !w_blocked) begin
            r_value  <= i_item.value;
            r_repeat <= w_rep_out;
            r_first  <= r_written[COUNT_BITS-1:0];
            r_over   <= w_over;
            r_done   <= w_done;
        end
    end

    assign o_valid          = r_valid;
    assign o_pixel_value    = r_value;
    assign o_repeat_count   = r_repeat;
    assign o_first_index    = r_first;
    assign o_overrun        = r_over;
    assign o_image_complete = r_done;
endmodule
`default_nettype wire

[design/tga_rle_pixel_decoder_core.sv]
`default_nettype none
// Run-length decoder for the image body of a TGA file.
// Channels: i_in takes one encoded byte per request; o_out gives one request per
// completed raw pixel or run (value, repeat count, first pixel index, overrun and
// image-complete flags); i_cfg writes bytes_per_pixel (index 0) and pixel_count
// (index 1) and is always ready. Write i_cfg only while the decoder is idle.
// Throughput: one byte per cycle, sustained, while o_out keeps taking results.
// On its way to o_out a result is registered in the pixel queue and then in the
// output register: the parser writes it into the queue when its last byte is
// taken, and the pixel counter moves it on once the output register is free or
// is being read out. Packet header bytes and leading pixel bytes give no result.
// The parser and the pixel counter are parted by a four-entry queue: when o_out
// stalls, the output register holds, the queue fills and i_in.ready drops only
// once it is full.
// After the last pixel of the image is written the decoder halts and takes but
// drops every further byte until reset.
// Reset (synchronous, i_rst_n low) sets bytes_per_pixel to 4, pixel_count to 1,
// clears the queue and the pixel counter and waits for a packet header byte.
module tga_rle_pixel_decoder_core #(
    parameter int COUNT_BITS = tga_rle_pkg::COUNT_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    tga_rle_in_if.sink     i_in,
    tga_rle_out_if.source  o_out,
    tga_rle_cfg_if.sink    i_cfg
);
    logic [2:0]          r_bpp;
    logic [COUNT_BITS:0] r_pixel_count;

    logic                w_stop;
    logic                w_push_valid;
    logic                w_push_ready;
    tga_rle_pkg::t_item  w_push_item;
    logic                w_pop_valid;
    logic                w_pop_ready;
    tga_rle_pkg::t_item  w_pop_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp         <= tga_rle_pkg::BPP_RESET;
            r_pixel_count <= (COUNT_BITS + 1)'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tga_rle_pkg::CFG_BPP:   r_bpp <= i_cfg.data[2:0];
                tga_rle_pkg::CFG_COUNT: r_pixel_count <= i_cfg.data;
                default: ;
            endcase
        end
    end

    tga_rle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bpp        (r_bpp),
        .i_stop       (w_stop),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_data_byte  (i_in.data_byte),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_item       (w_push_item)
    );

    tga_rle_fifo #(
        .DEPTH (tga_rle_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_item   (w_pop_item)
    );

    tga_rle_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pixel_count    (r_pixel_count),
        .o_stop           (w_stop),
        .i_pop_valid      (w_pop_valid),
        .o_pop_ready      (w_pop_ready),
        .i_item           (w_pop_item),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_pixel_value    (o_out.pixel_value),
        .o_repeat_count   (o_out.repeat_count),
        .o_first_index    (o_out.first_index),
        .o_overrun        (o_out.overrun),
        .o_image_complete (o_out.image_complete)
    );
endmodule
`default_nettype wire

[design/tga_rle_checker.sv]
`default_nettype none
`include "tga_rle_pixel_decoder_core_defines.svh"
module tga_rle_checker #(
    parameter int COUNT_BITS = tga_rle_pkg::COUNT_BITS_DEF
) (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_out_valid,
    input wire                               i_out_ready,
    input wire [tga_rle_pkg::PIX_BITS-1:0]   i_pixel_value,
    input wire [7:0]                         i_repeat_count,
    input wire [COUNT_BITS-1:0]              i_first_index,
    input wire                               i_overrun,
    input wire                               i_image_complete
);
    logic [tga_rle_pkg::PIX_BITS+COUNT_BITS+9:0] w_payload;
    logic                                        w_last_taken;

    assign w_payload    = {i_pixel_value, i_repeat_count, i_first_index,
                           i_overrun, i_image_complete};
    assign w_last_taken = i_out_valid && i_out_ready && i_image_complete;

    `TGA_ASSERT_NEXT(a_hold_stalled, i_out_valid && !i_out_ready, i_out_valid && $stable(w_payload), "stalled result changed")
    `TGA_ASSERT_NOW(a_repeat_range, i_out_valid, i_repeat_count != 8'd0 && i_repeat_count <= 8'd128, "repeat count out of range")
    `TGA_ASSERT_NOW(a_overrun_ends, i_out_valid && i_overrun, i_image_complete, "overrun without image end")
    `TGA_ASSERT_NEXT(a_halt_after_end, w_last_taken, !i_out_valid, "result after image end")
endmodule

bind tga_rle_pixel_decoder_core tga_rle_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_pixel_value    (o_out.pixel_value),
    .i_repeat_count   (o_out.repeat_count),
    .i_first_index    (o_out.first_index),
    .i_overrun        (o_out.overrun),
    .i_image_complete (o_out.image_complete)
);
`default_nettype wire
